// ----- rtl/cafe_pkg.sv -----
package cafe_pkg;

  typedef enum logic [5:0] {
    OP_CLEAR = 6'd0, OP_SETCOL = 6'd1, OP_NOP = 6'd2, OP_CONST = 6'd3, OP_LDCOL = 6'd4,
    OP_UADD = 6'd5, OP_USUB = 6'd6, OP_UMUL = 6'd7, OP_UDIV = 6'd8, OP_UMOD = 6'd9,
    OP_SADD = 6'd10, OP_SSUB = 6'd11, OP_SMUL = 6'd12, OP_SDIV = 6'd13, OP_SNEG = 6'd14,
    OP_EQ = 6'd15, OP_NE = 6'd16, OP_ULT = 6'd17, OP_ULE = 6'd18, OP_UGT = 6'd19,
    OP_UGE = 6'd20, OP_SLT = 6'd21, OP_SLE = 6'd22, OP_SGT = 6'd23, OP_SGE = 6'd24,
    OP_LAND = 6'd25, OP_LOR = 6'd26, OP_LNOT = 6'd27, OP_BAND = 6'd28, OP_BOR = 6'd29,
    OP_BXOR = 6'd30, OP_BNOT = 6'd31, OP_SEL = 6'd32, OP_RET = 6'd33
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ARITH = 2'd1, ST_UNIMPL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_ITER, S_DONE, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        is_mul;
  } iter_ctl_t;

endpackage

// ----- rtl/cafe_if.sv -----
interface cafe_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  func;
  logic [7:0]  dest;
  logic [7:0]  src_a;
  logic [7:0]  src_b;
  logic [7:0]  src_c;
  logic [3:0]  column;
  logic [63:0] immediate;
  logic        has_operand;
  modport source (output valid, func, dest, src_a, src_b, src_c, column, immediate,
                  has_operand, input ready);
  modport sink (input valid, func, dest, src_a, src_b, src_c, column, immediate,
                has_operand, output ready);
endinterface

interface cafe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value;
  logic        returned;
  logic        passes;
  modport source (output valid, status, value, returned, passes, input ready);
  modport sink (input valid, status, value, returned, passes, output ready);
endinterface

// ----- rtl/checked_alu_filter_executor.sv -----
// Filter program executor: one instruction per input transaction.
// Sequence: a and b are fetched at input accept, c is read in the read state, then the op
// executes; multiply and non-faulting divide first iterate in the bit-serial unit.
// Flow: one instruction at a time; next accepted the cycle after the result is taken.
// Reset (rst_n, synchronous): all store valid bits and event columns cleared.
module checked_alu_filter_executor
  import cafe_pkg::*;
#(
  parameter int VALUE_SLOTS   = 256,
  parameter int EVENT_COLUMNS = 12
) (
  input  logic  clk,
  input  logic  rst_n,
  cafe_in_if.sink    in_ch,
  cafe_out_if.source out_ch
);
  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

  state_t      state_r, state_nxt;
  logic [5:0]  func_r;
  logic [7:0]  dest_r, src_a_r, src_b_r, src_c_r;
  logic [3:0]  col_r;
  logic [63:0] imm_r;
  logic        hasop_r;
  logic [63:0] x_r, y_r;
  logic [7:0]  rd_a_idx, rd_b_idx;
  logic [63:0] rd_a_data, rd_b_data;
  logic [63:0] cols_r [EVENT_COLUMNS];

  logic        wr_en, clear;
  logic [63:0] res;
  logic        err, write, unimpl;
  logic [1:0]  status_r;
  logic [63:0] value_r;
  logic        returned_r, passes_r, ovalid_r;

  iter_ctl_t   ictl;
  logic        idone;
  logic [63:0] ilo, ihi;
  logic [63:0] ma, mb;
  logic        neg;

  assign ma  = x_r[63] ? (64'd0 - x_r) : x_r;
  assign mb  = y_r[63] ? (64'd0 - y_r) : y_r;
  assign neg = x_r[63] ^ y_r[63];

  // idle: fetch a,b straight from the input; read state: fetch c on port a
  always_comb begin
    case (state_r)
      S_IDLE: begin
        rd_a_idx = in_ch.src_a;
        rd_b_idx = in_ch.src_b;
      end
      S_READ: begin
        rd_a_idx = src_c_r;
        rd_b_idx = src_b_r;
      end
      default: begin
        rd_a_idx = src_a_r;
        rd_b_idx = src_b_r;
      end
    endcase
  end

  cafe_store #(.SLOTS(VALUE_SLOTS)) u_store (
    .clk(clk), .rst_n(rst_n),
    .rd_a_idx(rd_a_idx), .rd_b_idx(rd_b_idx),
    .rd_a_data(rd_a_data), .rd_b_data(rd_b_data),
    .wr_en(wr_en), .wr_idx(dest_r), .wr_data(res), .clear(clear)
  );

  logic is_mul, is_div, is_signed_md;
  always_comb begin
    is_mul = (func_r == OP_UMUL) || (func_r == OP_SMUL);
    is_div = (func_r == OP_UDIV) || (func_r == OP_UMOD) || (func_r == OP_SDIV);
    is_signed_md = (func_r == OP_SMUL) || (func_r == OP_SDIV);
  end

  // unsigned ops feed raw operands; signed multiply/divide feed magnitudes
  logic [63:0] iop_a, iop_b;
  assign iop_a = is_signed_md ? ma : x_r;
  assign iop_b = is_signed_md ? mb : y_r;

  cafe_iter u_iter (
    .clk(clk), .rst_n(rst_n), .ctl(ictl),
    .opa(iop_a), .opb(iop_b), .done(idone), .lo(ilo), .hi(ihi)
  );

  always_comb begin
    ictl.start  = (state_r == S_EXEC) && (is_mul || (is_div && y_r != 64'd0
                  && !(func_r == OP_SDIV && x_r == SIGN && y_r == '1)));
    ictl.is_div = is_div;
    ictl.is_mul = is_mul;
  end

  // ALU and result formation
  logic [63:0] qs, sm;
  logic        c_ovf;
  always_comb begin
    res = '0; err = 1'b0; write = 1'b1; unimpl = 1'b0;
    c_ovf = 1'b0; qs = '0; sm = '0;
    case (func_r)
      OP_CLEAR:  write = 1'b0;
      OP_SETCOL: write = 1'b0;
      OP_NOP:    write = 1'b0;
      OP_CONST:  res = imm_r;
      OP_LDCOL:  res = ({28'd0, col_r} < 32'(EVENT_COLUMNS)) ? cols_r[col_r] : 64'd0;
      OP_UADD: begin res = x_r + y_r; err = res < x_r; end
      OP_USUB: begin res = x_r - y_r; err = x_r < y_r; end
      OP_UMUL: begin res = ilo; err = ihi != 64'd0; end
      OP_UDIV: begin res = ilo; err = y_r == 64'd0; end
      OP_UMOD: begin res = ihi; err = y_r == 64'd0; end
      OP_SADD: begin res = x_r + y_r; err = ~(x_r[63] ^ y_r[63]) & (x_r[63] ^ res[63]); end
      OP_SSUB: begin res = x_r - y_r; err = (x_r[63] ^ y_r[63]) & (x_r[63] ^ res[63]); end
      OP_SMUL: begin
        sm = ilo;
        if (ihi != 64'd0) c_ovf = 1'b1;
        else if (neg && sm > SIGN) c_ovf = 1'b1;
        else if (!neg && sm > SIGN - 64'd1) c_ovf = 1'b1;
        err = c_ovf;
        res = neg ? (64'd0 - sm) : sm;
      end
      OP_SDIV: begin
        qs = ilo;
        err = (y_r == 64'd0) || (x_r == SIGN && y_r == '1);
        res = neg ? (64'd0 - qs) : qs;
      end
      OP_SNEG: begin res = 64'd0 - x_r; err = x_r == SIGN; end
      OP_EQ:   res = {63'd0, x_r == y_r};
      OP_NE:   res = {63'd0, x_r != y_r};
      OP_ULT:  res = {63'd0, x_r < y_r};
      OP_ULE:  res = {63'd0, x_r <= y_r};
      OP_UGT:  res = {63'd0, x_r > y_r};
      OP_UGE:  res = {63'd0, x_r >= y_r};
      OP_SLT:  res = {63'd0, $signed(x_r) < $signed(y_r)};
      OP_SLE:  res = {63'd0, $signed(x_r) <= $signed(y_r)};
      OP_SGT:  res = {63'd0, $signed(x_r) > $signed(y_r)};
      OP_SGE:  res = {63'd0, $signed(x_r) >= $signed(y_r)};
      OP_LAND: res = {63'd0, (x_r != 0) && (y_r != 0)};
      OP_LOR:  res = {63'd0, (x_r != 0) || (y_r != 0)};
      OP_LNOT: res = {63'd0, x_r == 0};
      OP_BAND: res = x_r & y_r;
      OP_BOR:  res = x_r | y_r;
      OP_BXOR: res = x_r ^ y_r;
      OP_BNOT: res = ~x_r;
      // select finishes in S_EXEC, where port a carries c
      OP_SEL:  res = (x_r != 0) ? y_r : rd_a_data;
      OP_RET:  write = 1'b0;
      default: begin write = 1'b0; unimpl = 1'b1; end
    endcase
  end

  logic fin;
  always_comb begin
    state_nxt = state_r;
    fin = 1'b0;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (ictl.start) state_nxt = S_ITER;
        else begin state_nxt = S_OUT; fin = 1'b1; end
      end
      S_ITER: if (idone) begin state_nxt = S_OUT; fin = 1'b1; end
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign wr_en = fin && write && !err;
  assign clear = fin && (func_r == OP_CLEAR);
  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      for (int i = 0; i < EVENT_COLUMNS; i++) cols_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      if (fin && func_r == OP_SETCOL && {28'd0, col_r} < 32'(EVENT_COLUMNS))
        cols_r[col_r] <= imm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r  <= in_ch.func;
      dest_r  <= in_ch.dest;
      src_a_r <= in_ch.src_a;
      src_b_r <= in_ch.src_b;
      src_c_r <= in_ch.src_c;
      col_r   <= in_ch.column;
      imm_r   <= in_ch.immediate;
      hasop_r <= in_ch.has_operand;
    end
    if (state_r == S_READ) begin
      x_r <= rd_a_data;
      y_r <= rd_b_data;
    end
    if (fin) begin
      returned_r <= (func_r == OP_RET);
      passes_r   <= (func_r == OP_RET) && hasop_r && (x_r != 0);
      if (unimpl) begin
        status_r <= ST_UNIMPL; value_r <= '0;
      end else if (err) begin
        status_r <= ST_ARITH; value_r <= '0;
      end else begin
        status_r <= ST_OK;
        value_r  <= (func_r == OP_SETCOL) ? imm_r :
                    (func_r == OP_RET) ? (hasop_r ? x_r : 64'd0) : res;
      end
    end
  end

  assign out_ch.valid    = ovalid_r && (state_r == S_OUT);
  assign out_ch.status   = status_r;
  assign out_ch.value    = value_r;
  assign out_ch.returned = returned_r;
  assign out_ch.passes   = passes_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("accepted while result pending");
  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    err && fin |-> !wr_en) else $error("store written on error");
  a_passes_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.passes |-> out_ch.returned) else $error("passes without return");
endmodule

// ----- rtl/cafe_iter.sv -----
// Shared iterative unit: unsigned 64x64 multiply (radix-2 shift-add, 128-bit
// product) and restoring divide, one bit per cycle; done flags the finished result.
module cafe_iter
  import cafe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  iter_ctl_t   ctl,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] lo,
  output logic [63:0] hi
);
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         div_r, div_nxt;
  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [64:0]  trial;
  logic [64:0]  psum;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    trial    = '0;
    psum     = '0;
    done     = busy_r && (cnt_r == 7'd64);
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = ctl.is_div;
      a_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == 7'd64) begin
        // done cycle: hold the result
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end else begin
        if (div_r) begin
          // acc hi = remainder, lo = quotient; a shifts dividend bits in
          trial = {acc_r[127:64], a_r[63]} - {1'b0, b_r};
          if (!trial[64]) begin
            acc_nxt = {trial[63:0], acc_r[62:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[126:64], a_r[63], acc_r[62:0], 1'b0};
          end
          a_nxt = {a_r[62:0], 1'b0};
        end else begin
          psum = {1'b0, acc_r[127:64]} + (a_r[0] ? {1'b0, b_r} : 65'd0);
          acc_nxt = {psum, acc_r[63:1]};
          a_nxt = {1'b0, a_r[63:1]};
        end
        cnt_nxt = cnt_r + 7'd1;
      end
    end
    lo = acc_r[63:0];
    hi = acc_r[127:64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end
endmodule

// ----- rtl/cafe_store.sv -----
// Value store: one synchronous memory with two read ports, one write port.
// Three operand reads are split: a and b together, then c on port a; valid bits live in flip-flops.
module cafe_store
  import cafe_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  rd_a_idx,
  input  logic [7:0]  rd_b_idx,
  output logic [63:0] rd_a_data,
  output logic [63:0] rd_b_data,
  input  logic        wr_en,
  input  logic [7:0]  wr_idx,
  input  logic [63:0] wr_data,
  input  logic        clear
);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [63:0]    mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [63:0]    qa_r, qb_r;
  logic           va_r, vb_r;
  logic           ina_ok, inb_ok, wr_ok;

  assign ina_ok = ({24'd0, rd_a_idx} < 32'(SLOTS));
  assign inb_ok = ({24'd0, rd_b_idx} < 32'(SLOTS));
  assign wr_ok  = ({24'd0, wr_idx} < 32'(SLOTS));

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_idx[AW-1:0]] <= wr_data;
    end
    qa_r <= mem[rd_a_idx[AW-1:0]];
    qb_r <= mem[rd_b_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
    end else begin
      va_r <= ina_ok && valid_r[rd_a_idx[AW-1:0]];
      vb_r <= inb_ok && valid_r[rd_b_idx[AW-1:0]];
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en && wr_ok) begin
        valid_r[wr_idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_a_data = va_r ? qa_r : 64'd0;
  assign rd_b_data = vb_r ? qb_r : 64'd0;
endmodule
